// ===== design/shortest_job_priority_queue_defines.svh =====
// assertion macros for the shortest job priority queue
`ifndef SHORTEST_JOB_PRIORITY_QUEUE_DEFINES_SVH
`define SHORTEST_JOB_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SJPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SJPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sjpq_pkg.sv =====
// shared types and constants of the shortest job priority queue
package sjpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int KEY_BITS_DEF    = 16;
    localparam int BURST_BITS      = 16;
    localparam int ID_BITS         = 8;
    localparam int STATUS_BITS     = 2;
    localparam int OCC_BITS        = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic                  cmd;
        logic [BURST_BITS-1:0] burst_time;
        logic [ID_BITS-1:0]    job_id;
    } t_item;

    typedef struct packed {
        logic [BURST_BITS-1:0] out_burst;
        logic [ID_BITS-1:0]    out_id;
        t_status               status;
        logic [OCC_BITS-1:0]   occupancy;
    } t_result;

    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_op;

endpackage

// ===== design/sjpq_cell.sv =====
// one storage cell of the sorted row: holds a key and id, shifts left or right
module sjpq_cell #(
    parameter int KEY_BITS = sjpq_pkg::KEY_BITS_DEF
) (
    input  logic                         i_clk,
    input  sjpq_pkg::t_cell_op           i_op,
    input  logic [KEY_BITS-1:0]          i_new_key,
    input  logic [sjpq_pkg::ID_BITS-1:0] i_new_id,
    input  logic                         i_occ,
    input  logic                         i_left_keep,
    input  logic [KEY_BITS-1:0]          i_left_key,
    input  logic [sjpq_pkg::ID_BITS-1:0] i_left_id,
    input  logic [KEY_BITS-1:0]          i_right_key,
    input  logic [sjpq_pkg::ID_BITS-1:0] i_right_id,
    output logic                         o_keep,
    output logic [KEY_BITS-1:0]          o_key,
    output logic [sjpq_pkg::ID_BITS-1:0] o_id
);
    import sjpq_pkg::*;

    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] n_key;
    logic [ID_BITS-1:0]  r_id;
    logic [ID_BITS-1:0]  n_id;

    // stays in place when its key is not above the new one (fifo among equals)
    assign o_keep = i_occ && (r_key <= i_new_key);
    assign o_key  = r_key;
    assign o_id   = r_id;

    always_comb begin
        n_key = r_key;
        n_id  = r_id;
        priority if (i_op.pop) begin
            n_key = i_right_key;
            n_id  = i_right_id;
        end else if (i_op.insert && !o_keep) begin
            if (i_left_keep) begin
                n_key = i_new_key;
                n_id  = i_new_id;
            end else begin
                n_key = i_left_key;
                n_id  = i_left_id;
            end
        end else begin
            n_key = r_key;
            n_id  = r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_id  <= n_id;
    end

endmodule

// ===== design/shortest_job_priority_queue.sv =====
// top level of the shortest job priority queue built as a row of sorted cells
//
// Input channel: an item (cmd, burst_time, job_id) is taken at a clock edge
// with start high and busy low. busy is always low, so one item can be taken
// in every cycle. cmd insert places the job behind all stored jobs of equal
// or smaller burst time; cmd pop removes the job with the smallest burst.
// Result channel: every item gives exactly one result, shown for a single
// cycle with o_strobe high, in the cycle after the item was taken. The result
// carries the popped job (zero otherwise), a status code and the occupancy
// after the item. The receiver cannot stall, so results are never held.
// Throughput is one item per cycle: each cell of the row compares its key
// with the broadcast key and shifts in parallel, so the whole row is updated
// at the edge that takes the item. An insert into a full queue is dropped and
// flagged, a pop from an empty queue is flagged and changes nothing.
// Reset clears the job count and the output strobe; the queue is empty and
// ready as soon as reset is released.
module shortest_job_priority_queue #(
    parameter int QUEUE_DEPTH = sjpq_pkg::QUEUE_DEPTH_DEF,
    parameter int KEY_BITS    = sjpq_pkg::KEY_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  sjpq_pkg::t_item   i_item,
    output logic              o_strobe,
    output sjpq_pkg::t_result o_result
);
    import sjpq_pkg::*;

    `include "shortest_job_priority_queue_defines.svh"

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_strobe;
    t_result             r_result;
    t_result             n_result;
    t_cell_op            w_op;
    logic [KEY_BITS-1:0] w_new_key;
    logic                w_full;
    logic                w_empty;

    logic                w_keep [QUEUE_DEPTH];
    logic [KEY_BITS-1:0] w_key  [QUEUE_DEPTH];
    logic [ID_BITS-1:0]  w_id   [QUEUE_DEPTH];

    assign busy      = 1'b0;
    assign w_new_key = KEY_BITS'(i_item.burst_time);
    assign w_full    = (r_count == CW'(QUEUE_DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_op.insert = start && (i_item.cmd == CMD_INSERT) && !w_full;
    assign w_op.pop    = start && (i_item.cmd == CMD_POP) && !w_empty;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                left_keep;
        logic [KEY_BITS-1:0] left_key;
        logic [ID_BITS-1:0]  left_id;
        logic [KEY_BITS-1:0] right_key;
        logic [ID_BITS-1:0]  right_id;

        if (g == 0) begin : g_head
            assign left_keep = 1'b1;
            assign left_key  = w_new_key;
            assign left_id   = i_item.job_id;
        end else begin : g_body
            assign left_keep = w_keep[g-1];
            assign left_key  = w_key[g-1];
            assign left_id   = w_id[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign right_key = w_new_key;
            assign right_id  = i_item.job_id;
        end else begin : g_inner
            assign right_key = w_key[g+1];
            assign right_id  = w_id[g+1];
        end

        sjpq_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op),
            .i_new_key   (w_new_key),
            .i_new_id    (i_item.job_id),
            .i_occ       (r_count > CW'(g)),
            .i_left_keep (left_keep),
            .i_left_key  (left_key),
            .i_left_id   (left_id),
            .i_right_key (right_key),
            .i_right_id  (right_id),
            .o_keep      (w_keep[g]),
            .o_key       (w_key[g]),
            .o_id        (w_id[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_op.insert) begin
            n_count = r_count + 1'b1;
        end else if (w_op.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        n_result.out_burst = '0;
        n_result.out_id    = '0;
        n_result.status    = ST_OK;
        if (i_item.cmd == CMD_INSERT) begin
            if (w_full) begin
                n_result.status = ST_FULL;
            end
        end else begin
            if (w_empty) begin
                n_result.status = ST_EMPTY;
            end else begin
                n_result.out_burst = BURST_BITS'(w_key[0]);
                n_result.out_id    = w_id[0];
            end
        end
        n_result.occupancy = OCC_BITS'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `SJPQ_ASSERT_NEXT(a_strobe_follows_start, start, o_strobe, "item gave no result")
    `SJPQ_ASSERT_NEXT(a_no_spurious_result, !start, !o_strobe, "result without an item")
    `SJPQ_ASSERT_NOW(a_count_bounded, 1'b1, r_count <= CW'(QUEUE_DEPTH), "count past depth")
    `SJPQ_ASSERT_NEXT(a_pop_shrinks, w_op.pop, r_count == $past(r_count) - 1'b1, "pop lost count")
    `SJPQ_ASSERT_NEXT(a_full_drop, start && i_item.cmd == CMD_INSERT && w_full,
        o_result.status == ST_FULL && $stable(r_count), "full insert not dropped")

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the shortest job priority queue: directed and random items
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sjpq_pkg::*;

    localparam int DEPTH        = QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 550;

    class sjpq_scoreboard;
        logic [KEY_BITS_DEF-1:0] job_keys[DEPTH];
        logic [ID_BITS-1:0]      job_ids[DEPTH];
        int                      job_count;
        t_result                 pending_results[$];
        int                      error_count;

        function new();
            job_count   = 0;
            error_count = 0;
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            error_count++;
        endtask

        function void note_item(input t_item item);
            t_result                 res;
            logic [KEY_BITS_DEF-1:0] key;
            int                      pos;
            res        = '0;
            res.status = ST_OK;
            key        = item.burst_time[KEY_BITS_DEF-1:0];
            if (item.cmd == CMD_INSERT) begin
                if (job_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < job_count && job_keys[pos] <= key) pos++;
                    for (int i = job_count; i > pos; i--) begin
                        job_keys[i] = job_keys[i-1];
                        job_ids[i]  = job_ids[i-1];
                    end
                    job_keys[pos] = key;
                    job_ids[pos]  = item.job_id;
                    job_count++;
                end
            end else begin
                if (job_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.out_burst = BURST_BITS'(job_keys[0]);
                    res.out_id    = job_ids[0];
                    for (int i = 1; i < job_count; i++) begin
                        job_keys[i-1] = job_keys[i];
                        job_ids[i-1]  = job_ids[i];
                    end
                    job_count--;
                end
            end
            res.occupancy = OCC_BITS'(job_count);
            pending_results.push_back(res);
        endfunction

        task check_result(input t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report("result with no item outstanding");
            end else begin
                want = pending_results.pop_front();
                if (got.out_burst !== want.out_burst)
                    report($sformatf("out_burst %0d, want %0d", got.out_burst, want.out_burst));
                if (got.out_id !== want.out_id)
                    report($sformatf("out_id %0d, want %0d", got.out_id, want.out_id));
                if (got.status !== want.status)
                    report($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.occupancy !== want.occupancy)
                    report($sformatf("occupancy %0d, want %0d", got.occupancy, want.occupancy));
            end
        endtask
    endclass

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    o_strobe;
    t_result o_result;
    int      cycle_count = 0;

    sjpq_scoreboard sb = new();

    shortest_job_priority_queue u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) sb.check_result(o_result);
            if (start && !busy) sb.note_item(i_item);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_item(input t_item item, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start  <= 1'b0;
            i_item <= t_item'({$urandom, $urandom});
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= item;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic insert_job(input logic [BURST_BITS-1:0] key, input logic [ID_BITS-1:0] id);
        t_item item;
        item.cmd        = CMD_INSERT;
        item.burst_time = key;
        item.job_id     = id;
        send_item(item, 0);
    endtask

    task automatic pop_job();
        t_item item;
        item.cmd        = CMD_POP;
        item.burst_time = BURST_BITS'($urandom);
        item.job_id     = ID_BITS'($urandom);
        send_item(item, 0);
    endtask

    function automatic t_item random_item(input int fill_pct);
        t_item item;
        item.cmd = ($urandom_range(0, 99) < fill_pct) ? CMD_INSERT : CMD_POP;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: item.burst_time = BURST_BITS'($urandom_range(0, 15));
            5:             item.burst_time = '0;
            6:             item.burst_time = '1;
            default:       item.burst_time = BURST_BITS'($urandom);
        endcase
        item.job_id = ID_BITS'($urandom);
        return item;
    endfunction

    initial begin
        logic [BURST_BITS-1:0] fill_keys[16];
        logic [ID_BITS-1:0]    fill_ids[16];
        int                    idle_by_phase[3];
        int                    fill_pct;
        int                    run_left;
        fill_keys     = '{16'd5, 16'd5, 16'd0, 16'hFFFF, 16'd5, 16'd0, 16'hFFFF, 16'd100,
                          16'd1, 16'h8000, 16'd7, 16'd5, 16'h0FFF, 16'd2, 16'hFFFE, 16'h5555};
        fill_ids      = '{8'd1, 8'd2, 8'hFF, 8'h00, 8'd3, 8'd4, 8'd5, 8'h80,
                          8'h7F, 8'h01, 8'hAA, 8'h55, 8'd9, 8'hFE, 8'h10, 8'h20};
        idle_by_phase = '{29, 67, 0};
        fill_pct      = 75;
        run_left      = 20;
        start   = 1'b0;
        i_item  = '0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pop on empty, fill with ties and extreme keys, insert on full, drain part way
        pop_job();
        for (int i = 0; i < 16; i++) insert_job(fill_keys[i], fill_ids[i]);
        insert_job(16'd3, 8'hC3);
        pop_job();
        insert_job(16'hAAAA, 8'h55);
        repeat (4) pop_job();

        for (int phase = 0; phase < 3; phase++) begin
            for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
                if (run_left == 0) begin
                    fill_pct = (fill_pct > 50) ? 30 : 75;
                    run_left = $urandom_range(15, 40);
                end
                run_left--;
                send_item(random_item(fill_pct), idle_by_phase[phase]);
            end
        end
        start <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.pending_results.size() != 0) sb.report("results missing at end of run");
        if (sb.error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
